### rtl/owpd_pkg.sv
// ----------------------------------------------------------------------------
// owpd_pkg: shared types and constants for the OOK pulse decoder
// Frame geometry, register indexes, result codes, the queue entry type
// and the pulse window check.
// ----------------------------------------------------------------------------
package owpd_pkg;

   // Frame geometry.
   localparam int FRAME_PULSES   = 88;
   localparam int CODE_BITS      = 44;
   localparam int LAST_GAP_INDEX = 85;
   localparam int COUNT_W        = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // Field widths.
   localparam int DUR_W     = 16;
   localparam int ID_W      = 8;
   localparam int TOL_W     = 7;
   localparam int STATUS_W  = 3;
   localparam int READING_W = 12;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Type codes and offsets.
   localparam logic [11:0] TYPE_TEMP = 12'h0a0;
   localparam logic [11:0] TYPE_HUM  = 12'h0ae;
   localparam logic [READING_W-1:0] TEMP_OFFSET = 12'd500;

   // Register reset values.
   localparam logic [ID_W-1:0]  SENSOR_ID_RST = 8'd0;
   localparam logic [TOL_W-1:0] TOL_RST       = 7'd25;
   localparam logic [DUR_W-1:0] ONE_MARK_RST  = 16'd550;
   localparam logic [DUR_W-1:0] ZERO_MARK_RST = 16'd1400;
   localparam logic [DUR_W-1:0] GAP_RST       = 16'd1000;

   // Depth of the queue between classifier and assembler.
   localparam int QUEUE_DEPTH = 2;

   // Register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SENSOR_ID = 3'd0,
      CSR_TOL_PCT   = 3'd1,
      CSR_ONE_MARK  = 3'd2,
      CSR_ZERO_MARK = 3'd3,
      CSR_GAP       = 3'd4
   } csr_index_type;

   // Result status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_TEMP      = 3'd0,
      ST_HUMIDITY  = 3'd1,
      ST_OTHER     = 3'd2,
      ST_BAD_LEN   = 3'd3,
      ST_BAD_TIME  = 3'd4,
      ST_BAD_CHECK = 3'd5,
      ST_BAD_ID    = 3'd6
   } status_type;

   // Timing configuration seen by the classifier.
   typedef struct packed {
      logic [TOL_W-1:0] tol_pct;
      logic [DUR_W-1:0] one_mark;
      logic [DUR_W-1:0] zero_mark;
      logic [DUR_W-1:0] gap;
   } timing_cfg_type;

   // One classified pulse, as it travels through the queue.
   typedef struct packed {
      logic shift_en;   // pulse is a bit slot: shift bit_val into the code
      logic bit_val;
      logic err;        // pulse violates its timing window or level
      logic len_ok;     // pulse is the one that brings the count to a full frame
      logic last;       // pulse closes the frame
   } pulse_class_type;

   // Window check without a divider: floor(x/100) <= d holds exactly when
   // x < 100*(d+1), and d <= floor(x/100) holds exactly when 100*d <= x.
   function automatic logic in_window(logic [DUR_W-1:0] dur,
                                      logic [DUR_W-1:0] nom,
                                      logic [TOL_W-1:0] tol);
      logic [23:0] hi_prod;
      logic [23:0] lo_prod;
      logic [23:0] dur_x100;
      logic        lo_ok;
      hi_prod  = 24'(8'(tol) + 8'd100) * 24'(nom);
      lo_prod  = 24'(7'd100 - tol) * 24'(nom);
      dur_x100 = 24'(dur) * 24'd100;
      lo_ok    = (tol >= 7'd100) || (lo_prod < (dur_x100 + 24'd100));
      return (dur_x100 <= hi_prod) && lo_ok;
   endfunction

endpackage

### rtl/owpd_front.sv
// ----------------------------------------------------------------------------
// owpd_front: pulse classifier
// Counts pulses in the frame and checks each against its timing window,
// producing one classified entry per accepted beat.
// ----------------------------------------------------------------------------
module owpd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  owpd_pkg::timing_cfg_type        cfg,
   input  logic                            in_fire,
   input  logic                            is_mark,
   input  logic [owpd_pkg::DUR_W-1:0]      duration_us,
   input  logic                            frame_end,
   output owpd_pkg::pulse_class_type       entry
);
   import owpd_pkg::*;

   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               one_hit;
   logic               zero_hit;
   logic               gap_hit;
   logic               bit_slot;
   logic               gap_slot;

   // Windows for the three nominal widths.
   assign one_hit  = in_window(duration_us, cfg.one_mark, cfg.tol_pct);
   assign zero_hit = in_window(duration_us, cfg.zero_mark, cfg.tol_pct);
   assign gap_hit  = in_window(duration_us, cfg.gap, cfg.tol_pct);

   // Even positions carry bits, odd positions up to the last gap are spaces.
   assign bit_slot = (count_ff < COUNT_W'(FRAME_PULSES)) && !count_ff[0];
   assign gap_slot = (count_ff <= COUNT_W'(LAST_GAP_INDEX)) && count_ff[0];

   // Classified entry for the current beat.
   always_comb begin
      entry.shift_en = bit_slot;
      entry.bit_val  = is_mark && one_hit;
      entry.err      = (bit_slot && !(is_mark && (one_hit || zero_hit))) ||
                       (gap_slot && (is_mark || !gap_hit));
      entry.len_ok   = (count_ff == COUNT_W'(FRAME_PULSES - 1));
      entry.last     = frame_end;
   end

   // Saturating pulse counter, cleared at the end of each frame.
   always_comb begin
      count_in = count_ff;
      if (in_fire) begin
         if (frame_end) begin
            count_in = '0;
         end else if (count_ff != COUNT_MAX) begin
            count_in = count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

### rtl/owpd_queue.sv
// ----------------------------------------------------------------------------
// owpd_queue: classified pulse queue
// A short FIFO that lets the classifier and the assembler stall on their own.
// ----------------------------------------------------------------------------
module owpd_queue #(
   parameter int DEPTH = owpd_pkg::QUEUE_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  owpd_pkg::pulse_class_type  push_entry,
   output logic                       full,
   input  logic                       pop,
   output logic                       head_valid,
   output owpd_pkg::pulse_class_type  head_entry
);
   import owpd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   pulse_class_type    slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   // Pointer and fill count update with wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   // The fill count stays within the storage.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count exceeds depth");

   // Entries are never taken from an empty queue.
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   // A lone pop lowers the fill count by one.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("queue count did not follow a pop");

endmodule

### rtl/owpd_back.sv
// ----------------------------------------------------------------------------
// owpd_back: code assembler and result builder
// Shifts decoded bits into the code, gathers timing errors and, on the
// last pulse of a frame, checks and decodes the code into the result register.
// ----------------------------------------------------------------------------
module owpd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [owpd_pkg::ID_W-1:0]            sensor_id,
   input  logic                                 head_valid,
   input  owpd_pkg::pulse_class_type            head_entry,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [owpd_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [owpd_pkg::READING_W-1:0] rsp_reading_tenths,
   output logic [owpd_pkg::CODE_BITS-1:0]       rsp_raw_code
);
   import owpd_pkg::*;

   logic [CODE_BITS-1:0] code_ff;
   logic [CODE_BITS-1:0] code_in;
   logic                 terr_ff;
   logic                 terr_in;
   logic                 valid_ff;
   logic                 valid_in;
   logic                 load;
   logic [CODE_BITS-1:0] code_now;
   logic                 terr_now;
   status_type           status_in;
   logic [READING_W-1:0] reading_in;
   logic [CODE_BITS-1:0] raw_in;
   logic [3:0]           v1;
   logic [3:0]           v2;
   logic [3:0]           v3;
   logic [READING_W-1:0] value;
   logic [STATUS_W-1:0]  status_ff;
   logic [READING_W-1:0] reading_ff;
   logic [CODE_BITS-1:0] raw_ff;

   // A closing pulse waits until the result register is free.
   assign pop  = head_valid && (!head_entry.last || !valid_ff || !rsp_stall);
   assign load = pop && head_entry.last;

   // Code and error state including the pulse at the head.
   assign code_now = head_entry.shift_en ? {code_ff[CODE_BITS-2:0], head_entry.bit_val}
                                         : code_ff;
   assign terr_now = terr_ff || head_entry.err;

   always_comb begin
      code_in = code_ff;
      terr_in = terr_ff;
      if (pop) begin
         code_in = head_entry.last ? '0 : code_now;
         terr_in = head_entry.last ? 1'b0 : terr_now;
      end
   end

   // Digit fields and the reading value.
   assign v1    = code_now[15:12];
   assign v2    = code_now[19:16];
   assign v3    = code_now[23:20];
   assign value = READING_W'(v1) + READING_W'(v2) * READING_W'(10)
                + READING_W'(v3) * READING_W'(100);

   // Frame checks in priority order.
   always_comb begin
      status_in  = ST_OTHER;
      reading_in = '0;
      raw_in     = code_now;
      if (!head_entry.len_ok) begin
         status_in = ST_BAD_LEN;
         raw_in    = '0;
      end else if (terr_now) begin
         status_in = ST_BAD_TIME;
         raw_in    = '0;
      end else if ((v2 != code_now[7:4]) || (v3 != code_now[11:8])) begin
         status_in = ST_BAD_CHECK;
      end else if (code_now[32:25] != sensor_id) begin
         status_in = ST_BAD_ID;
      end else if (code_now[43:32] == TYPE_TEMP) begin
         status_in  = ST_TEMP;
         reading_in = value - TEMP_OFFSET;
      end else if (code_now[43:32] == TYPE_HUM) begin
         status_in  = ST_HUMIDITY;
         reading_in = value;
      end
   end

   // Result register valid flag.
   always_comb begin
      valid_in = valid_ff && rsp_stall;
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff  <= '0;
         terr_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         code_ff  <= code_in;
         terr_ff  <= terr_in;
         valid_ff <= valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         status_ff  <= status_in;
         reading_ff <= reading_in;
         raw_ff     <= raw_in;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_reading_tenths = signed'(reading_ff);
   assign rsp_raw_code       = raw_ff;

endmodule

### rtl/ook_weather_sensor_pulse_decoder.sv
// Throughput: one pulse beat per cycle while the queue is not full; a frame has 88 pulses.
// The result beat is registered: the frame_end beat passes through the queue, then loads the result register.
// The classifier and the assembler meet in a small queue, so a stalled result
// holds back input only once that queue fills.
// Reset is synchronous: it clears the pulse count, code, queue and result valid,
// and returns the registers to their default values.
// ----------------------------------------------------------------------------
// ook_weather_sensor_pulse_decoder: OOK pulse-width weather sensor decoder
// Classifies received pulses, assembles the 44-bit code and reports
// the sensor reading or the reason a frame was rejected.
// ----------------------------------------------------------------------------
module ook_weather_sensor_pulse_decoder #(
   parameter int QUEUE_DEPTH = owpd_pkg::QUEUE_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_en,
   input  logic [owpd_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [owpd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_is_mark,
   input  logic [owpd_pkg::DUR_W-1:0]            req_duration_us,
   input  logic                                  req_frame_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [owpd_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [owpd_pkg::READING_W-1:0] rsp_reading_tenths,
   output logic [owpd_pkg::CODE_BITS-1:0]        rsp_raw_code
);
   import owpd_pkg::*;

   logic [ID_W-1:0]  sensor_id_ff;
   timing_cfg_type   tcfg_ff;
   logic             q_full;
   logic             in_fire;
   logic             q_pop;
   logic             q_head_valid;
   pulse_class_type  q_push_entry;
   pulse_class_type  q_head_entry;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_id_ff      <= SENSOR_ID_RST;
         tcfg_ff.tol_pct   <= TOL_RST;
         tcfg_ff.one_mark  <= ONE_MARK_RST;
         tcfg_ff.zero_mark <= ZERO_MARK_RST;
         tcfg_ff.gap       <= GAP_RST;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_SENSOR_ID: sensor_id_ff      <= csr_wdata[ID_W-1:0];
            CSR_TOL_PCT:   tcfg_ff.tol_pct   <= csr_wdata[TOL_W-1:0];
            CSR_ONE_MARK:  tcfg_ff.one_mark  <= csr_wdata[DUR_W-1:0];
            CSR_ZERO_MARK: tcfg_ff.zero_mark <= csr_wdata[DUR_W-1:0];
            CSR_GAP:       tcfg_ff.gap       <= csr_wdata[DUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input handshake: stall only while the queue is full.
   assign req_stall = q_full;
   assign in_fire   = req_valid && !q_full;

   owpd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (tcfg_ff),
      .in_fire     (in_fire),
      .is_mark     (req_is_mark),
      .duration_us (req_duration_us),
      .frame_end   (req_frame_end),
      .entry       (q_push_entry)
   );

   owpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (in_fire),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_entry (q_head_entry)
   );

   owpd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .sensor_id          (sensor_id_ff),
      .head_valid         (q_head_valid),
      .head_entry         (q_head_entry),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_reading_tenths (rsp_reading_tenths),
      .rsp_raw_code       (rsp_raw_code)
   );

endmodule
